/* hw/rtl/kalman_tilt_angle_filter_assert.svh */
// Assertion macros for the Kalman tilt filter.
// Included by the top level; depends on nothing else.
`ifndef KALMAN_TILT_ANGLE_FILTER_ASSERT_SVH
`define KALMAN_TILT_ANGLE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KTA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kalman tilt filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KTA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kalman tilt filter assertion failed");

`endif

/* hw/rtl/kta_pkg.sv */
// Shared widths, register indexes, reset values and helpers of the tilt filter.
// Used by the interfaces, the arithmetic units and the top level.
package kta_pkg;

   localparam int SAMPLE_W  = 32;   // Q16.16 samples and results
   localparam int CFG_W     = 47;   // unsigned Q7.40 registers
   localparam int STATE_W   = 48;   // signed state words
   localparam int OPND_W    = 50;   // signed multiplier operands
   localparam int PROD_W    = 58;   // signed scaled product
   localparam int SUM_W     = 60;   // state plus product before clamping
   localparam int CSR_IDX_W = 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_BIAS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_MEAS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 2'd3;

   // Reset values in Q7.40: about 0.001, 0.003, 0.5 and 0.005.
   localparam logic [CFG_W-1:0] RST_NOISE_ANGLE = 47'd1099511628;
   localparam logic [CFG_W-1:0] RST_NOISE_BIAS  = 47'd3298534883;
   localparam logic [CFG_W-1:0] RST_NOISE_MEAS  = 47'd549755813888;
   localparam logic [CFG_W-1:0] RST_TIME_STEP   = 47'd5497558139;

   localparam logic signed [STATE_W-1:0] ONE_Q740 = 48'sh0100_0000_0000;

   // Handshake status of an iterative unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // Clamp a wide sum to the signed 48-bit state range.
   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:STATE_W-1] == '0) || (v[SUM_W-1:STATE_W-1] == '1);
      if (fits) begin
         return v[STATE_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

endpackage

/* hw/rtl/kta_req_if.sv */
// Sample channel of the tilt filter: valid, ready and the two input fields.
// Depends on kta_pkg.
interface kta_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [kta_pkg::SAMPLE_W-1:0] measured_angle;
   logic signed [kta_pkg::SAMPLE_W-1:0] gyro_rate;

   modport source (output valid, output measured_angle, output gyro_rate, input ready);
   modport sink   (input valid, input measured_angle, input gyro_rate, output ready);
endinterface

/* hw/rtl/kta_rsp_if.sv */
// Result channel of the tilt filter: valid, ready and the two output fields.
// Depends on kta_pkg.
interface kta_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [kta_pkg::SAMPLE_W-1:0] filtered_angle;
   logic signed [kta_pkg::SAMPLE_W-1:0] corrected_rate;

   modport source (output valid, output filtered_angle, output corrected_rate, input ready);
   modport sink   (input valid, input filtered_angle, input corrected_rate, output ready);
endinterface

/* hw/rtl/kta_mul.sv */
// Shared Q7.40 multiplier: four 32x32 partial products, accumulated one at a time.
// Result is floor(a*b / 2^40). Depends on kta_pkg.
module kta_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [kta_pkg::OPND_W-1:0]   a,
   input  logic signed [kta_pkg::OPND_W-1:0]   b,
   output kta_pkg::unit_stat_type              stat,
   output logic signed [kta_pkg::PROD_W-1:0]   result
);

   localparam int MAG_W = kta_pkg::OPND_W - 1;
   localparam int ACC_W = 98;

   logic [MAG_W-1:0] xmag_ff, xmag_in, ymag_ff, ymag_in;
   logic             neg_ff, neg_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [63:0]      pp_ff, pp_in;
   logic [1:0]       pshift_ff, pshift_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic signed [kta_pkg::PROD_W-1:0] result_ff, result_in;

   logic [31:0]      opx, opy;
   logic [ACC_W-1:0] pp_shifted;
   logic [ACC_W-41:0] mag_q;
   logic             rem_nz;

   // Select the halves for this cycle's partial product.
   always_comb begin
      opx = cnt_ff[1] ? {15'd0, xmag_ff[MAG_W-1:32]} : xmag_ff[31:0];
      opy = cnt_ff[0] ? {15'd0, ymag_ff[MAG_W-1:32]} : ymag_ff[31:0];
   end

   // Align the registered partial product to its weight.
   always_comb begin
      unique case (pshift_ff)
         2'd0:    pp_shifted = {34'd0, pp_ff};
         2'd1:    pp_shifted = {2'd0, pp_ff, 32'd0};
         default: pp_shifted = {pp_ff[33:0], 64'd0};
      endcase
   end

   assign mag_q  = acc_ff[ACC_W-1:40];
   assign rem_nz = |acc_ff[39:0];

   // Sequencing of the partial products and the final scaling.
   always_comb begin
      xmag_in   = xmag_ff;
      ymag_in   = ymag_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      pp_in     = 64'(opx * opy);
      pshift_in = 2'({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]});
      acc_in    = acc_ff;
      result_in = result_ff;
      if (start) begin
         xmag_in = a[kta_pkg::OPND_W-1] ? MAG_W'(-a) : a[MAG_W-1:0];
         ymag_in = b[kta_pkg::OPND_W-1] ? MAG_W'(-b) : b[MAG_W-1:0];
         neg_in  = a[kta_pkg::OPND_W-1] ^ b[kta_pkg::OPND_W-1];
         cnt_in  = 3'd0;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd0 && cnt_ff <= 3'd4) begin
            acc_in = acc_ff + pp_shifted;
         end
         if (cnt_ff == 3'd5) begin
            result_in = neg_ff ? -$signed(mag_q) - $signed({57'd0, rem_nz})
                               : $signed(mag_q);
            busy_in   = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      xmag_ff   <= xmag_in;
      ymag_ff   <= ymag_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      pp_ff     <= pp_in;
      pshift_ff <= pshift_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = result_ff;

endmodule

/* hw/rtl/kta_div.sv */
// Gain divider: (num << 40) / den, one restoring step per cycle.
// Truncates toward zero and clamps to the signed 48-bit range. Depends on kta_pkg.
module kta_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [kta_pkg::STATE_W-1:0]  num,
   input  logic [kta_pkg::STATE_W-1:0]         den,
   output kta_pkg::unit_stat_type              stat,
   output logic signed [kta_pkg::STATE_W-1:0]  result
);

   localparam int W  = kta_pkg::STATE_W;
   localparam int QW = W - 1;

   logic [W-1:0]  d_ff, d_in, rem_ff, rem_in;
   logic [QW-1:0] nbits_ff, nbits_in, q_ff, q_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          neg_ff, neg_in, over_ff, over_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic signed [W-1:0] result_ff, result_in;

   logic [W:0]    n_full;
   logic [W-1:0]  n_mag;
   logic [W:0]    shifted;
   logic          fits;

   assign n_full  = num[W-1] ? ((W+1)'(0) - {num[W-1], num}) : {1'b0, num};
   assign n_mag   = n_full[W-1:0];
   assign shifted = {rem_ff, nbits_ff[QW-1]};
   assign fits    = shifted >= {1'b0, d_ff};

   // One quotient bit per cycle; a quotient of 2^47 or more clamps.
   always_comb begin
      d_in      = d_ff;
      rem_in    = rem_ff;
      nbits_in  = nbits_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      over_in   = over_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         d_in     = den;
         rem_in   = {7'd0, n_mag[W-1:7]};
         nbits_in = {n_mag[6:0], 40'd0};
         q_in     = '0;
         cnt_in   = 6'(QW);
         neg_in   = num[W-1];
         over_in  = {7'd0, n_mag[W-1:7]} >= den;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != 6'd0) begin
            rem_in   = fits ? W'(shifted - {1'b0, d_ff}) : shifted[W-1:0];
            q_in     = {q_ff[QW-2:0], fits};
            nbits_in = {nbits_ff[QW-2:0], 1'b0};
            cnt_in   = cnt_ff - 6'd1;
         end else begin
            if (over_ff) begin
               result_in = neg_ff ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
            end else begin
               result_in = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff      <= d_in;
      rem_ff    <= rem_in;
      nbits_ff  <= nbits_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      over_ff   <= over_in;
      result_ff <= result_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = result_ff;

endmodule

/* hw/rtl/kalman_tilt_angle_filter.sv */
// Two-state Kalman tilt filter: sequencer, state registers and result register.
// Depends on kta_pkg, kta_req_if, kta_rsp_if, kta_mul, kta_div and the assert header.
//
// Usage:
//   req_chan carries one sample (measured_angle, gyro_rate, Q16.16); it is taken when
//   valid and ready are both high. rsp_chan returns one result (filtered_angle,
//   corrected_rate, Q16.16) per sample, in order. The csr_ port writes the four Q7.40
//   registers (indexes 0 to 3); the user must write only while idle, unenforced.
// Sequencing:
//   From transfer to result, one sample takes ten products on the shared
//   multiplier, two gain divisions on the bit-serial divider, and a load of
//   the result register. When the innovation variance is not positive the
//   divisions are skipped. req_chan.ready is high only while no sample is in
//   work, so a new sample is taken only once the last result is loaded.
// Reset:
//   Reset clears estimates, sets the covariance to identity and the registers
//   to their defaults. No clearing pass is needed.
// Stalls:
//   A finished result waits in the output register; a new sample is taken
//   meanwhile, and its result waits until the earlier one is transferred.
`include "kalman_tilt_angle_filter_assert.svh"

module kalman_tilt_angle_filter (
   input  logic                              clock,
   input  logic                              reset,
   kta_req_if.sink                           req_chan,
   kta_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [kta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kta_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int SW = kta_pkg::STATE_W;
   localparam int OW = kta_pkg::OPND_W;
   localparam int XW = kta_pkg::SUM_W;
   localparam int DW = kta_pkg::SAMPLE_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   // Micro-operations in execution order.
   localparam logic [3:0] OP_ANG_P  = 4'd0;
   localparam logic [3:0] OP_P00_P  = 4'd1;
   localparam logic [3:0] OP_P01_P  = 4'd2;
   localparam logic [3:0] OP_P11_P  = 4'd3;
   localparam logic [3:0] OP_K0     = 4'd4;
   localparam logic [3:0] OP_K1     = 4'd5;
   localparam logic [3:0] OP_P10_U  = 4'd6;
   localparam logic [3:0] OP_P11_U  = 4'd7;
   localparam logic [3:0] OP_P01_U  = 4'd8;
   localparam logic [3:0] OP_P00_U  = 4'd9;
   localparam logic [3:0] OP_BIAS_U = 4'd10;
   localparam logic [3:0] OP_ANG_U  = 4'd11;

   logic [1:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;

   logic [kta_pkg::CFG_W-1:0] pna_ff, pnb_ff, rn_ff, dt_ff;
   logic signed [SW-1:0] angle_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [SW-1:0] k0_ff, k1_ff;
   logic signed [DW-1:0] meas_ff, gyro_ff;
   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_angle_ff, rsp_rate_ff;

   logic signed [OW-1:0] gyro_q, meas_q, rate_diff, err, d00, innov;
   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [SW-1:0] div_num;
   logic                 e_pos, mul_start, div_start, unit_done, is_div, wb_sub;
   logic signed [SW-1:0] wb_base, wb_val, wb_p10;
   logic signed [kta_pkg::PROD_W-1:0] mul_res;
   logic signed [SW-1:0] div_res;
   kta_pkg::unit_stat_type mul_stat, div_stat;
   logic                 req_fire, rsp_fire, out_load;
   logic signed [33:0]   rate_out;

   // Sign-extended operands for the micro-operations and the divider.
   assign gyro_q    = {{2{gyro_ff[DW-1]}}, gyro_ff, 16'd0};
   assign meas_q    = {{2{meas_ff[DW-1]}}, meas_ff, 16'd0};
   assign rate_diff = gyro_q - {{2{bias_ff[SW-1]}}, bias_ff};
   assign err       = meas_q - {{2{angle_ff[SW-1]}}, angle_ff};
   assign d00       = {3'd0, pna_ff} - {{2{p01_ff[SW-1]}}, p01_ff}
                                     - {{2{p10_ff[SW-1]}}, p10_ff};
   assign innov     = {3'd0, rn_ff} + {{2{p00_ff[SW-1]}}, p00_ff};
   assign e_pos     = !innov[OW-1] && (innov != '0);

   // Operand selection for the shared units.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      div_num = p00_ff;
      wb_base = angle_ff;
      wb_sub  = 1'b0;
      is_div  = 1'b0;
      unique case (op_ff)
         OP_ANG_P: begin
            mul_a = rate_diff; mul_b = {3'd0, dt_ff}; wb_base = angle_ff;
         end
         OP_P00_P: begin
            mul_a = d00; mul_b = {3'd0, dt_ff}; wb_base = p00_ff;
         end
         OP_P01_P: begin
            mul_a = -{{2{p11_ff[SW-1]}}, p11_ff}; mul_b = {3'd0, dt_ff}; wb_base = p01_ff;
         end
         OP_P11_P: begin
            mul_a = {3'd0, pnb_ff}; mul_b = {3'd0, dt_ff}; wb_base = p11_ff;
         end
         OP_K0: begin
            is_div = 1'b1; div_num = p00_ff;
         end
         OP_K1: begin
            is_div = 1'b1; div_num = p10_ff;
         end
         OP_P10_U: begin
            mul_a = OW'(k1_ff); mul_b = OW'(p00_ff); wb_base = p10_ff; wb_sub = 1'b1;
         end
         OP_P11_U: begin
            mul_a = OW'(k1_ff); mul_b = OW'(p01_ff); wb_base = p11_ff; wb_sub = 1'b1;
         end
         OP_P01_U: begin
            mul_a = OW'(k0_ff); mul_b = OW'(p01_ff); wb_base = p01_ff; wb_sub = 1'b1;
         end
         OP_P00_U: begin
            mul_a = OW'(k0_ff); mul_b = OW'(p00_ff); wb_base = p00_ff; wb_sub = 1'b1;
         end
         OP_BIAS_U: begin
            mul_a = OW'(k1_ff); mul_b = err; wb_base = bias_ff;
         end
         OP_ANG_U: begin
            mul_a = OW'(k0_ff); mul_b = err; wb_base = angle_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Saturating write-back of state plus or minus the product.
   assign wb_val = kta_pkg::sat48(wb_sub ? XW'(wb_base) - XW'(mul_res)
                                         : XW'(wb_base) + XW'(mul_res));
   assign wb_p10 = kta_pkg::sat48(XW'(p10_ff) + XW'(mul_res));

   assign mul_start = (state_ff == ST_ISSUE) && !is_div;
   assign div_start = (state_ff == ST_ISSUE) && is_div && e_pos;
   assign unit_done = mul_stat.done || div_stat.done;

   kta_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .stat   (mul_stat),
      .result (mul_res)
   );

   kta_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (innov[SW-1:0]),
      .stat   (div_stat),
      .result (div_res)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_ISSUE;
               op_in    = OP_ANG_P;
            end
         end
         ST_ISSUE: begin
            if (is_div && !e_pos) begin
               op_in = OP_P10_U;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (unit_done) begin
               if (op_ff == OP_ANG_U) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_ISSUE;
                  op_in    = op_ff + 4'd1;
               end
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ANG_P;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pna_ff <= kta_pkg::RST_NOISE_ANGLE;
         pnb_ff <= kta_pkg::RST_NOISE_BIAS;
         rn_ff  <= kta_pkg::RST_NOISE_MEAS;
         dt_ff  <= kta_pkg::RST_TIME_STEP;
      end else if (csr_we) begin
         unique case (csr_index)
            kta_pkg::CSR_NOISE_ANGLE: pna_ff <= csr_wdata;
            kta_pkg::CSR_NOISE_BIAS:  pnb_ff <= csr_wdata;
            kta_pkg::CSR_NOISE_MEAS:  rn_ff  <= csr_wdata;
            kta_pkg::CSR_TIME_STEP:   dt_ff  <= csr_wdata;
            default:                  dt_ff  <= dt_ff;
         endcase
      end
   end

   // Sample capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         meas_ff <= req_chan.measured_angle;
         gyro_ff <= req_chan.gyro_rate;
      end
   end

   // Filter state, updated one micro-operation at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         bias_ff  <= '0;
         p00_ff   <= kta_pkg::ONE_Q740;
         p01_ff   <= '0;
         p10_ff   <= '0;
         p11_ff   <= kta_pkg::ONE_Q740;
         k0_ff    <= '0;
         k1_ff    <= '0;
      end else if (state_ff == ST_ISSUE && is_div && !e_pos) begin
         k0_ff <= '0;
         k1_ff <= '0;
      end else if (state_ff == ST_WAIT && unit_done) begin
         unique case (op_ff)
            OP_ANG_P, OP_ANG_U:            angle_ff <= wb_val;
            OP_BIAS_U:                     bias_ff  <= wb_val;
            OP_P00_P, OP_P00_U:            p00_ff   <= wb_val;
            OP_P01_P: begin
               p01_ff <= wb_val;
               p10_ff <= wb_p10;
            end
            OP_P01_U:                      p01_ff   <= wb_val;
            OP_P10_U:                      p10_ff   <= wb_val;
            OP_P11_P, OP_P11_U:            p11_ff   <= wb_val;
            OP_K0:                         k0_ff    <= div_res;
            OP_K1:                         k1_ff    <= div_res;
            default:                       angle_ff <= angle_ff;
         endcase
      end
   end

   // Result register; it holds until the receiver takes the transfer.
   assign rate_out = rate_diff[OW-1:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_angle_ff <= angle_ff[SW-1:16];
         if (rate_out[33:31] == 3'b000 || rate_out[33:31] == 3'b111) begin
            rsp_rate_ff <= rate_out[DW-1:0];
         end else if (rate_out[33]) begin
            rsp_rate_ff <= {1'b1, {(DW-1){1'b0}}};
         end else begin
            rsp_rate_ff <= {1'b0, {(DW-1){1'b1}}};
         end
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_angle = rsp_angle_ff;
   assign rsp_chan.corrected_rate = rsp_rate_ff;

   // Checks on the sequencer and the shared units.
   `KTA_ASSERT_NEXT(a_busy_after_take, clock, reset, req_fire, state_ff != ST_IDLE)
   `KTA_ASSERT_NOW(a_done_while_wait, clock, reset, unit_done, state_ff == ST_WAIT)
   `KTA_ASSERT_NOW(a_one_unit_busy, clock, reset, mul_stat.busy, !div_stat.busy)
   `KTA_ASSERT_NEXT(a_result_loaded, clock, reset, out_load, rsp_valid_ff)

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the two-state Kalman tilt filter.
// Depends on kta_pkg, kta_req_if, kta_rsp_if and kalman_tilt_angle_filter.
// A fixed-point predictor runs alongside the block and checks every result transfer.
module tb_top;

   localparam int  HALF_PERIOD    = 6;
   localparam int  STEP_LATENCY   = 250;
   localparam int  WATCHDOG_LIMIT = 6000;
   localparam int  ITEMS_PER_PHASE = 200;
   localparam int  PHASE_COUNT    = 8;
   localparam longint CFG_MAX     = (64'sd1 <<< kta_pkg::CFG_W) - 1;
   localparam longint S48_MAX     = (64'sd1 <<< 47) - 1;
   localparam longint S48_MIN     = -(64'sd1 <<< 47);
   localparam longint WIDE_LIM    = 64'sd1 <<< 62;

   typedef struct packed {
      logic [kta_pkg::SAMPLE_W-1:0] filtered_angle;
      logic [kta_pkg::SAMPLE_W-1:0] corrected_rate;
   } tilt_result_type;

   typedef struct {
      logic signed [kta_pkg::SAMPLE_W-1:0] measured_angle;
      logic signed [kta_pkg::SAMPLE_W-1:0] gyro_rate;
      bit                                  typed;
      tilt_result_type                     result;
   } sample_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [kta_pkg::CSR_IDX_W-1:0] csr_index;
   logic [kta_pkg::CFG_W-1:0]     csr_wdata;

   kta_req_if req_chan ();
   kta_rsp_if rsp_chan ();

   kalman_tilt_angle_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the configuration and the filter state.
   longint noise_angle, noise_bias, noise_meas, time_step;
   longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;

   tilt_result_type expected_results[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic longint clamp48(longint v);
      if (v > S48_MAX) return S48_MAX;
      if (v < S48_MIN) return S48_MIN;
      return v;
   endfunction

   // Exact product scaled by 2^-40, rounded toward minus infinity, clamped to 2^62.
   function automatic longint scaled_product(longint a, longint b);
      logic [127:0] prod;
      logic [63:0]  ma, mb, mag;
      bit           neg, frac;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      mag  = prod[103:40];
      frac = |prod[39:0];
      if (prod[127:104] != 0 || mag > 64'(WIDE_LIM)) return neg ? -WIDE_LIM : WIDE_LIM;
      if (neg) return -$signed(mag) - longint'(frac);
      return $signed(mag);
   endfunction

   // Kalman gain: (num << 40) / den, truncated toward zero, saturated.
   function automatic longint gain_quotient(longint num, longint den);
      logic [127:0] quo;
      logic [63:0]  mn;
      mn  = (num < 0) ? -num : num;
      quo = ({64'd0, mn} << 40) / {64'd0, 64'(den)};
      if (quo >= (128'd1 << 48)) quo = 128'd1 << 48;
      return clamp48((num < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]));
   endfunction

   function automatic void tilt_reset_state();
      noise_angle = kta_pkg::RST_NOISE_ANGLE;
      noise_bias  = kta_pkg::RST_NOISE_BIAS;
      noise_meas  = kta_pkg::RST_NOISE_MEAS;
      time_step   = kta_pkg::RST_TIME_STEP;
      angle_est = 0;
      bias_est  = 0;
      p_aa = 64'sd1 <<< 40;
      p_ab = 0;
      p_ba = 0;
      p_bb = 64'sd1 <<< 40;
   endfunction

   // One predict and update step; returns the result the block must produce.
   function automatic tilt_result_type tilt_predict(
         logic signed [kta_pkg::SAMPLE_W-1:0] meas_in,
         logic signed [kta_pkg::SAMPLE_W-1:0] gyro_in);
      longint meas, gyro, d00, err, innov, k0, k1, t0, t1, rate;
      tilt_result_type res;
      meas = longint'(meas_in) * 65536;
      gyro = longint'(gyro_in) * 65536;
      k0 = 0;
      k1 = 0;
      angle_est = clamp48(angle_est + scaled_product(gyro - bias_est, time_step));
      d00  = noise_angle - p_ab - p_ba;
      p_aa = clamp48(p_aa + scaled_product(d00, time_step));
      p_ab = clamp48(p_ab + scaled_product(-p_bb, time_step));
      p_ba = clamp48(p_ba + scaled_product(-p_bb, time_step));
      p_bb = clamp48(p_bb + scaled_product(noise_bias, time_step));
      err   = meas - angle_est;
      innov = noise_meas + p_aa;
      // A nonpositive innovation variance leaves both gains at zero.
      if (innov > 0) begin
         k0 = gain_quotient(p_aa, innov);
         k1 = gain_quotient(p_ba, innov);
      end
      t0 = p_aa;
      t1 = p_ab;
      p_aa = clamp48(p_aa - scaled_product(k0, t0));
      p_ab = clamp48(p_ab - scaled_product(k0, t1));
      p_ba = clamp48(p_ba - scaled_product(k1, t0));
      p_bb = clamp48(p_bb - scaled_product(k1, t1));
      angle_est = clamp48(angle_est + scaled_product(k0, err));
      bias_est  = clamp48(bias_est + scaled_product(k1, err));
      res.filtered_angle = 32'(angle_est >>> 16);
      rate = (gyro - bias_est) >>> 16;
      if (rate > 64'sd2147483647) rate = 64'sd2147483647;
      if (rate < -64'sd2147483648) rate = -64'sd2147483648;
      res.corrected_rate = 32'(rate);
      return res;
   endfunction

   // Result side: random stalls, compare each transfer with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: filtered_angle=%h corrected_rate=%h",
                      rsp_chan.filtered_angle, rsp_chan.corrected_rate);
               error_count++;
            end else begin
               tilt_result_type exp_res;
               exp_res = expected_results.pop_front();
               if (rsp_chan.filtered_angle !== exp_res.filtered_angle) begin
                  $error("filtered_angle: expected %h, actual %h",
                         exp_res.filtered_angle, rsp_chan.filtered_angle);
                  error_count++;
               end
               if (rsp_chan.corrected_rate !== exp_res.corrected_rate) begin
                  $error("corrected_rate: expected %h, actual %h",
                         exp_res.corrected_rate, rsp_chan.corrected_rate);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_register(logic [kta_pkg::CSR_IDX_W-1:0] idx, longint value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[kta_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         kta_pkg::CSR_NOISE_ANGLE: noise_angle = value;
         kta_pkg::CSR_NOISE_BIAS:  noise_bias  = value;
         kta_pkg::CSR_NOISE_MEAS:  noise_meas  = value;
         default:                  time_step   = value;
      endcase
   endtask

   // Wait until every expected result has arrived and the block has gone quiet.
   task automatic drain_results();
      @(posedge clock);
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (STEP_LATENCY) @(posedge clock);
   endtask

   // Offer one sample and hold it until the transfer.
   task automatic send_sample(logic signed [kta_pkg::SAMPLE_W-1:0] meas,
                              logic signed [kta_pkg::SAMPLE_W-1:0] gyro,
                              bit typed, tilt_result_type typed_res);
      tilt_result_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         @(posedge clock);
         req_chan.valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      @(posedge clock);
      req_chan.valid          <= 1'b1;
      req_chan.measured_angle <= meas;
      req_chan.gyro_rate      <= gyro;
      do @(posedge clock); while (!req_chan.ready);
      res = tilt_predict(meas, gyro);
      expected_results.push_back(typed ? typed_res : res);
   endtask

   function automatic logic [kta_pkg::SAMPLE_W-1:0] random_field();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1, 2, 3: return $urandom;
         default: return 32'($signed($urandom_range(2 * 5898240)) - 5898240);
      endcase
   endfunction

   function automatic longint random_setting(longint low);
      case ($urandom_range(3))
         0:       return low;
         1:       return CFG_MAX;
         2:       return longint'({$urandom, $urandom}) & CFG_MAX;
         default: return longint'($urandom_range(32'hFFFF_FFFF)) << $urandom_range(8);
      endcase
   endfunction

   sample_row_type directed_rows[12] = '{
      '{32'sh0000_0000, 32'sh0000_0000, 1'b1, '{32'h0, 32'h0}},
      '{32'sh0000_0000, 32'sh0000_0000, 1'b1, '{32'h0, 32'h0}},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '{32'h0, 32'h0}},
      '{32'sh8000_0000, 32'sh8000_0000, 1'b0, '{32'h0, 32'h0}},
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '{32'h0, 32'h0}},
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, '{32'h0, 32'h0}},
      '{32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, '{32'h0, 32'h0}},
      '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, '{32'h0, 32'h0}},
      '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, '{32'h0, 32'h0}},
      '{32'sh0001_0000, 32'sh0000_8000, 1'b0, '{32'h0, 32'h0}},
      '{32'shFFFF_0000, 32'shFFFF_8000, 1'b0, '{32'h0, 32'h0}},
      '{32'sh002D_0000, 32'sh0000_0000, 1'b0, '{32'h0, 32'h0}}
   };

   // Stimulus: directed rows at reset settings, then random phases.
   initial begin
      tilt_result_type none;
      int idle_modes[4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{28, 28}};
      none = '0;
      reset = 1'b1;
      csr_we <= 1'b0;
      csr_index <= kta_pkg::CSR_NOISE_ANGLE;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.measured_angle <= '0;
      req_chan.gyro_rate <= '0;
      tilt_reset_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].measured_angle, directed_rows[i].gyro_rate,
                     directed_rows[i].typed, directed_rows[i].result);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_results();
         send_idle_pct  = idle_modes[ph % 4][0];
         recv_stall_pct = idle_modes[ph % 4][1];
         // Settings walk through the extremes, then random mixes, then back to reset.
         case (ph)
            0: begin
               write_register(kta_pkg::CSR_NOISE_ANGLE, CFG_MAX);
               write_register(kta_pkg::CSR_NOISE_BIAS, CFG_MAX);
               write_register(kta_pkg::CSR_NOISE_MEAS, CFG_MAX);
               write_register(kta_pkg::CSR_TIME_STEP, CFG_MAX);
            end
            1: begin
               write_register(kta_pkg::CSR_NOISE_ANGLE, 0);
               write_register(kta_pkg::CSR_NOISE_BIAS, 0);
               write_register(kta_pkg::CSR_NOISE_MEAS, 1);
               write_register(kta_pkg::CSR_TIME_STEP, 1);
            end
            2: begin
               write_register(kta_pkg::CSR_NOISE_ANGLE, 0);
               write_register(kta_pkg::CSR_NOISE_BIAS, CFG_MAX);
               write_register(kta_pkg::CSR_NOISE_MEAS, 1);
               write_register(kta_pkg::CSR_TIME_STEP, CFG_MAX);
            end
            PHASE_COUNT - 1: begin
               write_register(kta_pkg::CSR_NOISE_ANGLE, kta_pkg::RST_NOISE_ANGLE);
               write_register(kta_pkg::CSR_NOISE_BIAS, kta_pkg::RST_NOISE_BIAS);
               write_register(kta_pkg::CSR_NOISE_MEAS, kta_pkg::RST_NOISE_MEAS);
               write_register(kta_pkg::CSR_TIME_STEP, kta_pkg::RST_TIME_STEP);
            end
            default: begin
               write_register(kta_pkg::CSR_NOISE_ANGLE, random_setting(0));
               write_register(kta_pkg::CSR_NOISE_BIAS, random_setting(0));
               write_register(kta_pkg::CSR_NOISE_MEAS, random_setting(1));
               write_register(kta_pkg::CSR_TIME_STEP, random_setting(1));
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Hold off once mid-phase until the result queue is empty.
            if (n == ITEMS_PER_PHASE / 2 && ph == 3) begin
               @(posedge clock);
               req_chan.valid <= 1'b0;
               while (expected_results.size() != 0) @(posedge clock);
            end
            send_sample(random_field(), random_field(), 1'b0, none);
         end
      end

      @(posedge clock);
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (STEP_LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* kalman_tilt_angle_filter.f */
+incdir+hw/rtl
hw/rtl/kta_pkg.sv
hw/rtl/kta_req_if.sv
hw/rtl/kta_rsp_if.sv
hw/rtl/kta_mul.sv
hw/rtl/kta_div.sv
hw/rtl/kalman_tilt_angle_filter.sv
verif/tb_top.sv
